[rtl/core/sparse_octree_insert_defines.svh]
// ----------------------------------------------------------------------------
// sparse_octree_insert_defines.svh
// Assertion macros for the sparse octree insert block.
// ----------------------------------------------------------------------------
`ifndef SPARSE_OCTREE_INSERT_DEFINES_SVH
`define SPARSE_OCTREE_INSERT_DEFINES_SVH
`ifndef SYNTH
// a holds in a cycle, then c holds in the same cycle
`define SOI_ASSERT_IMP(name, a, c, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) else $error(msg);
// a holds in a cycle, then c holds in the next cycle
`define SOI_ASSERT_NXT(name, a, c, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) else $error(msg);
`else
`define SOI_ASSERT_IMP(name, a, c, msg)
`define SOI_ASSERT_NXT(name, a, c, msg)
`endif
`endif

[rtl/core/soi_pkg.sv]
// ----------------------------------------------------------------------------
// soi_pkg
// Shared types, codes and defaults of the sparse octree insert block.
// ----------------------------------------------------------------------------
package soi_pkg;

  // defaults of the top level parameters
  localparam int unsigned NODE_CAPACITY_DEF     = 4096;
  localparam int unsigned COORD_BITS_DEF        = 16;
  localparam int unsigned INITIAL_ROOT_SIZE_DEF = 1;
  localparam int unsigned COLOR_BITS_DEF        = 32;

  // fixed widths
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LVL_W  = 5;
  localparam int unsigned CRD_W  = 32;
  localparam int unsigned IN_CRD_W = 16;
  localparam logic [LVL_W-1:0] LVL_LIMIT = 5'd31;

  // slot selection
  localparam logic [2:0] SLOT_MASK = 3'b111;
  localparam logic [2:0] FLIP_X    = 3'b100;
  localparam logic [2:0] FLIP_Y    = 3'b010;
  localparam logic [2:0] FLIP_Z    = 3'b001;

  // request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // one pool node: level and eight child slots
  typedef struct packed {
    logic [LVL_W-1:0]            level;
    logic [7:0][WORD_W-1:0]      link;
  } row_t;

  // true when c lies outside a root of the given level (level >= 1)
  function automatic logic outside(logic signed [CRD_W-1:0] c, logic [LVL_W-1:0] lvl);
    logic signed [CRD_W-1:0] s;
    s = c >>> (lvl - 5'd1);
    return !((s == '0) || (s == '1));
  endfunction

endpackage

[rtl/core/soi_ram.sv]
// ----------------------------------------------------------------------------
// soi_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module soi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write has priority; read data is registered and appears in the cycle after the read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sparse_octree_insert.sv]
// ----------------------------------------------------------------------------
// sparse_octree_insert
// Sparse voxel octree kept in a pool of nodes: insert and word read.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low; its result is
// shown for one cycle with done_o and must be taken then. All nodes live in
// one single-port node memory (one row per node: level and eight links),
// and every insert is a read-modify-write walk over it. A read goes through
// a memory read and S_RDATA, or answers from idle without a memory read
// when the node index is beyond the nodes in use. An insert reads the root,
// then runs root growth steps (a check, eight slot moves and a root
// write-back each) and walks down the root level. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`include "sparse_octree_insert_defines.svh"

module sparse_octree_insert #(
  parameter int unsigned NODE_CAPACITY     = soi_pkg::NODE_CAPACITY_DEF,
  parameter int unsigned COORD_BITS        = soi_pkg::COORD_BITS_DEF,
  parameter int unsigned INITIAL_ROOT_SIZE = soi_pkg::INITIAL_ROOT_SIZE_DEF,
  parameter int unsigned COLOR_BITS        = soi_pkg::COLOR_BITS_DEF,
  localparam int unsigned IDX_W = $clog2(NODE_CAPACITY),
  localparam int unsigned CNT_W = $clog2(NODE_CAPACITY + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  output logic                               done_o,
  input  logic                               req_type_i,
  input  logic signed [soi_pkg::IN_CRD_W-1:0] pos_x_i,
  input  logic signed [soi_pkg::IN_CRD_W-1:0] pos_y_i,
  input  logic signed [soi_pkg::IN_CRD_W-1:0] pos_z_i,
  input  logic [soi_pkg::WORD_W-1:0]         voxel_color_i,
  input  logic [IDX_W-1:0]                   node_select_i,
  input  logic [2:0]                         slot_select_i,
  output logic [1:0]                         status_o,
  output logic [IDX_W-1:0]                   leaf_node_o,
  output logic [soi_pkg::LVL_W-1:0]          root_size_o,
  output logic [CNT_W-1:0]                   used_count_o,
  output logic [soi_pkg::WORD_W-1:0]         read_word_o,
  output logic [soi_pkg::LVL_W-1:0]          read_level_o
);

  localparam int unsigned CW = soi_pkg::CRD_W;
  localparam int unsigned LW = soi_pkg::LVL_W;
  localparam int unsigned WW = soi_pkg::WORD_W;
  localparam int unsigned CSH = CW - COORD_BITS;
  localparam logic [WW-1:0] COLOR_MASK = WW'((64'd1 << COLOR_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(NODE_CAPACITY);

  // sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_RDATA     = 4'd1;
  localparam logic [3:0] S_GROW_RD   = 4'd2;
  localparam logic [3:0] S_GROW_CHK  = 4'd3;
  localparam logic [3:0] S_GROW_MOVE = 4'd4;
  localparam logic [3:0] S_GROW_END  = 4'd5;
  localparam logic [3:0] S_DESC      = 4'd6;
  localparam logic [3:0] S_DESC_RD   = 4'd7;
  localparam logic [3:0] S_DESC_NEW  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [LW-1:0] root_level_q, root_level_d;
  logic root_valid_q, root_valid_d;
  logic rd_root_q, rd_root_d;

  logic signed [CW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [WW-1:0] color_q, color_d;
  logic [IDX_W-1:0] node_sel_q, node_sel_d;
  logic [2:0] slot_sel_q, slot_sel_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [LW-1:0] lvl_q, lvl_d;
  logic [2:0] idx_q, idx_d;
  soi_pkg::row_t row_q, row_d;

  logic done_q, done_d;
  logic [1:0] status_q, status_d;
  logic [IDX_W-1:0] leaf_q, leaf_d;
  logic [WW-1:0] word_q, word_d;
  logic [LW-1:0] rlevel_q, rlevel_d;

  logic ram_we, ram_re;
  logic [IDX_W-1:0] ram_addr;
  soi_pkg::row_t ram_wdata, ram_rdata, row_in;

  soi_ram #(
    .WIDTH ($bits(soi_pkg::row_t)),
    .DEPTH (NODE_CAPACITY)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // root row reads as empty until first written
  assign row_in = (rd_root_q && !root_valid_q) ? '0 : ram_rdata;

  // coordinates reduced to COORD_BITS two's complement
  logic signed [CW-1:0] x_ext, y_ext, z_ext;
  always_comb begin
    x_ext = (CW'(pos_x_i) <<< CSH) >>> CSH;
    y_ext = (CW'(pos_y_i) <<< CSH) >>> CSH;
    z_ext = (CW'(pos_z_i) <<< CSH) >>> CSH;
  end

  // growth: count present root children
  logic [3:0] need;
  logic grow;
  always_comb begin
    need = '0;
    for (int i = 0; i < 8; i++) begin
      need = need + 4'(row_q.link[i] != '0);
    end
    grow = (root_level_q < soi_pkg::LVL_LIMIT) &&
           (soi_pkg::outside(x_q, root_level_q) || soi_pkg::outside(y_q, root_level_q) ||
            soi_pkg::outside(z_q, root_level_q));
  end

  // descent: slot, link and next coordinates
  logic [2:0] slot;
  logic [WW-1:0] link;
  logic link_ok;
  logic [LW-1:0] nlvl;
  logic signed [CW-1:0] q, x_n, y_n, z_n;
  always_comb begin
    slot = soi_pkg::SLOT_MASK ^ (x_q[CW-1] ? soi_pkg::FLIP_X : 3'b000)
                              ^ (y_q[CW-1] ? soi_pkg::FLIP_Y : 3'b000)
                              ^ (z_q[CW-1] ? soi_pkg::FLIP_Z : 3'b000);
    link = row_q.link[slot];
    link_ok = (link != '0) && (link < WW'(used_q));
    nlvl = lvl_q - 5'd1;
    q = (nlvl != '0) ? (CW'(1) <<< (nlvl - 5'd1)) : '0;
    x_n = x_q[CW-1] ? x_q + q : x_q - q;
    y_n = y_q[CW-1] ? y_q + q : y_q - q;
    z_n = z_q[CW-1] ? z_q + q : z_q - q;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    used_d = used_q;
    root_level_d = root_level_q;
    root_valid_d = root_valid_q;
    rd_root_d = rd_root_q;
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    color_d = color_q;
    node_sel_d = node_sel_q;
    slot_sel_d = slot_sel_q;
    cur_d = cur_q;
    lvl_d = lvl_q;
    idx_d = idx_q;
    row_d = row_q;
    done_d = 1'b0;
    status_d = status_q;
    leaf_d = leaf_q;
    word_d = word_q;
    rlevel_d = rlevel_q;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_addr = '0;
    ram_wdata = row_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d = x_ext;
          y_d = y_ext;
          z_d = z_ext;
          color_d = voxel_color_i & COLOR_MASK;
          node_sel_d = node_select_i;
          slot_sel_d = slot_select_i;
          if (req_type_i == soi_pkg::REQ_READ) begin
            if (CNT_W'(node_select_i) >= used_q) begin
              done_d = 1'b1;
              status_d = soi_pkg::ST_RANGE;
              leaf_d = '0;
              word_d = '0;
              rlevel_d = '0;
            end else begin
              ram_re = 1'b1;
              ram_addr = node_select_i;
              rd_root_d = (node_select_i == '0);
              state_d = S_RDATA;
            end
          end else begin
            ram_re = 1'b1;
            ram_addr = '0;
            rd_root_d = 1'b1;
            state_d = S_GROW_RD;
          end
        end
      end
      S_RDATA: begin
        done_d = 1'b1;
        status_d = soi_pkg::ST_OK;
        leaf_d = '0;
        word_d = row_in.link[slot_sel_q];
        rlevel_d = (node_sel_q == '0) ? root_level_q : row_in.level;
        state_d = S_IDLE;
      end
      S_GROW_RD: begin
        row_d = row_in;
        state_d = S_GROW_CHK;
      end
      S_GROW_CHK: begin
        if (!grow) begin
          cur_d = '0;
          lvl_d = root_level_q;
          state_d = S_DESC;
        end else if ((CNT_W+1)'(used_q) + (CNT_W+1)'(need) > (CNT_W+1)'(CAP)) begin
          done_d = 1'b1;
          status_d = soi_pkg::ST_FULL;
          leaf_d = '0;
          word_d = '0;
          rlevel_d = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = '0;
          state_d = S_GROW_MOVE;
        end
      end
      S_GROW_MOVE: begin
        // push one present root child down into a fresh node
        if (row_q.link[idx_q] != '0) begin
          ram_we = 1'b1;
          ram_addr = used_q[IDX_W-1:0];
          ram_wdata = '0;
          ram_wdata.level = root_level_q;
          ram_wdata.link[soi_pkg::SLOT_MASK ^ idx_q] = row_q.link[idx_q];
          row_d.link[idx_q] = WW'(used_q);
          used_d = used_q + 1'b1;
        end
        idx_d = idx_q + 3'd1;
        if (idx_q == soi_pkg::SLOT_MASK) begin
          state_d = S_GROW_END;
        end
      end
      S_GROW_END: begin
        ram_we = 1'b1;
        ram_addr = '0;
        ram_wdata = row_q;
        root_valid_d = 1'b1;
        root_level_d = root_level_q + 5'd1;
        state_d = S_GROW_CHK;
      end
      S_DESC: begin
        if (lvl_q == '0) begin
          // leaf: colour into slot 0
          ram_we = 1'b1;
          ram_addr = cur_q;
          ram_wdata = row_q;
          ram_wdata.link[0] = color_q;
          if (cur_q == '0) begin
            root_valid_d = 1'b1;
          end
          done_d = 1'b1;
          status_d = soi_pkg::ST_OK;
          leaf_d = cur_q;
          word_d = '0;
          rlevel_d = '0;
          state_d = S_IDLE;
        end else if (link_ok) begin
          cur_d = link[IDX_W-1:0];
          lvl_d = nlvl;
          x_d = x_n;
          y_d = y_n;
          z_d = z_n;
          ram_re = 1'b1;
          ram_addr = link[IDX_W-1:0];
          rd_root_d = 1'b0;
          state_d = S_DESC_RD;
        end else if (used_q >= CAP) begin
          done_d = 1'b1;
          status_d = soi_pkg::ST_FULL;
          leaf_d = '0;
          word_d = '0;
          rlevel_d = '0;
          state_d = S_IDLE;
        end else begin
          // link the new child into the current node
          ram_we = 1'b1;
          ram_addr = cur_q;
          ram_wdata = row_q;
          ram_wdata.link[slot] = WW'(used_q);
          if (cur_q == '0) begin
            root_valid_d = 1'b1;
          end
          lvl_d = nlvl;
          x_d = x_n;
          y_d = y_n;
          z_d = z_n;
          state_d = S_DESC_NEW;
        end
      end
      S_DESC_RD: begin
        row_d = row_in;
        state_d = S_DESC;
      end
      S_DESC_NEW: begin
        ram_we = 1'b1;
        ram_addr = used_q[IDX_W-1:0];
        ram_wdata = '0;
        ram_wdata.level = lvl_q;
        row_d = '0;
        row_d.level = lvl_q;
        cur_d = used_q[IDX_W-1:0];
        used_d = used_q + 1'b1;
        state_d = S_DESC;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= CNT_W'(1);
      root_level_q <= LW'(INITIAL_ROOT_SIZE);
      root_valid_q <= 1'b0;
      rd_root_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      root_level_q <= root_level_d;
      root_valid_q <= root_valid_d;
      rd_root_q <= rd_root_d;
      done_q <= done_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    color_q <= color_d;
    node_sel_q <= node_sel_d;
    slot_sel_q <= slot_sel_d;
    cur_q <= cur_d;
    lvl_q <= lvl_d;
    idx_q <= idx_d;
    row_q <= row_d;
    status_q <= status_d;
    leaf_q <= leaf_d;
    word_q <= word_d;
    rlevel_q <= rlevel_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign status_o = status_q;
  assign leaf_node_o = leaf_q;
  assign root_size_o = root_level_q;
  assign used_count_o = used_q;
  assign read_word_o = word_q;
  assign read_level_o = rlevel_q;

  // checks
  `SOI_ASSERT_IMP(a_used_cap, 1'b1, used_q <= CAP, "node count beyond capacity")
  `SOI_ASSERT_NXT(a_level_mono, 1'b1, root_level_q >= $past(root_level_q), "root level fell")
  `SOI_ASSERT_IMP(a_leaf_alloc, done_q && (status_q == soi_pkg::ST_OK), CNT_W'(leaf_q) < used_q, "leaf not allocated")

endmodule

[tb/sparse_octree_insert_tb.sv]
// ----------------------------------------------------------------------------
// sparse_octree_insert_tb
// Self-checking bench: directed table, then random inserts and pool reads.
// ----------------------------------------------------------------------------
// Every accepted request is run through a behavioural octree model in the
// bench, and the expected result is queued. Each done_o strobe is compared
// field by field with the oldest queued result. The random part favours
// clustered points, so that paths are shared, and also fills the pool.
// ----------------------------------------------------------------------------
module sparse_octree_insert_tb;

  localparam int unsigned NODES    = soi_pkg::NODE_CAPACITY_DEF;
  localparam int unsigned N_RANDOM = 1600;
  localparam int unsigned WD_LIMIT = 5000;
  localparam int unsigned TAIL     = 250;

  typedef struct {
    logic [1:0]  status;
    logic [11:0] leaf;
    logic [4:0]  root;
    logic [12:0] used;
    logic [31:0] word;
    logic [4:0]  rlevel;
  } octree_res_t;

  typedef struct {
    logic               req;
    logic signed [15:0] x, y, z;
    logic [31:0]        col;
    logic [11:0]        node;
    logic [2:0]         slot;
    bit                 typed;
    logic [1:0]         status;
    logic [11:0]        leaf;
    logic [4:0]         root;
    logic [12:0]        used;
    logic [31:0]        word;
    logic [4:0]         rlevel;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               done_o;
  logic               req_type_i;
  logic signed [15:0] pos_x_i, pos_y_i, pos_z_i;
  logic [31:0]        voxel_color_i;
  logic [11:0]        node_select_i;
  logic [2:0]         slot_select_i;
  logic [1:0]         status_o;
  logic [11:0]        leaf_node_o;
  logic [4:0]         root_size_o;
  logic [12:0]        used_count_o;
  logic [31:0]        read_word_o;
  logic [4:0]         read_level_o;

  // bench copy of the node pool
  logic [31:0] pool_links [NODES*8];
  logic [4:0]  pool_levels [NODES];
  int unsigned pool_used;
  int unsigned tree_level;

  octree_res_t pending_res [$];
  int unsigned n_errors, n_inserts, n_reads, n_full, n_range, idle_cycles;
  stim_row_t   dir_tab [13];

  sparse_octree_insert DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .done_o,
    .req_type_i, .pos_x_i, .pos_y_i, .pos_z_i, .voxel_color_i,
    .node_select_i, .slot_select_i,
    .status_o, .leaf_node_o, .root_size_o, .used_count_o,
    .read_word_o, .read_level_o
  );

  // clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // take a fresh pool node at the given level
  function automatic int unsigned alloc_node(int unsigned lvl);
    int unsigned n;
    n = pool_used;
    pool_used++;
    for (int s = 0; s < 8; s++) pool_links[n*8+s] = '0;
    pool_levels[n] = lvl[4:0];
    return n;
  endfunction

  function automatic bit beyond_root(longint c, int unsigned lvl);
    longint half;
    half = longint'(1) << (lvl - 1);
    return (c < -half) || (c >= half);
  endfunction

  // grow the root, descend by coordinate signs, store the colour
  function automatic logic [1:0] insert_voxel(longint x, longint y, longint z,
                                              logic [31:0] col,
                                              output logic [11:0] leaf);
    int unsigned need, cur, lvl, link, n;
    logic [2:0]  slot;
    longint      q;
    leaf = '0;
    while (tree_level < soi_pkg::LVL_LIMIT && (beyond_root(x, tree_level) ||
           beyond_root(y, tree_level) || beyond_root(z, tree_level))) begin
      need = 0;
      for (int i = 0; i < 8; i++) if (pool_links[i] != 0) need++;
      if (NODES - pool_used < need) return soi_pkg::ST_FULL;
      for (int i = 0; i < 8; i++) begin
        if (pool_links[i] != 0) begin
          n = alloc_node(tree_level);
          pool_links[n*8 + (soi_pkg::SLOT_MASK - i)] = pool_links[i];
          pool_links[i] = n;
        end
      end
      tree_level++;
      pool_levels[0] = tree_level[4:0];
    end
    cur = 0;
    lvl = tree_level;
    while (lvl > 0) begin
      slot = soi_pkg::SLOT_MASK;
      if (x < 0) slot ^= soi_pkg::FLIP_X;
      if (y < 0) slot ^= soi_pkg::FLIP_Y;
      if (z < 0) slot ^= soi_pkg::FLIP_Z;
      link = pool_links[cur*8 + slot];
      if (link == 0 || link >= pool_used) begin
        if (pool_used >= NODES) return soi_pkg::ST_FULL;
        link = alloc_node(lvl - 1);
        pool_links[cur*8 + slot] = link;
      end
      cur = link;
      lvl--;
      if (lvl > 0) begin
        q = longint'(1) << (lvl - 1);
        x += (x < 0) ? q : -q;
        y += (y < 0) ? q : -q;
        z += (z < 0) ? q : -q;
      end
    end
    pool_links[cur*8] = col;
    leaf = cur[11:0];
    return soi_pkg::ST_OK;
  endfunction

  // expected result of one request; updates the bench pool
  function automatic octree_res_t octree_predict(stim_row_t r);
    octree_res_t e;
    e = '{default: '0};
    if (r.req == soi_pkg::REQ_INSERT) begin
      e.status = insert_voxel(longint'(r.x), longint'(r.y), longint'(r.z), r.col, e.leaf);
      if (e.status != soi_pkg::ST_OK) e.leaf = '0;
    end else if (r.node >= pool_used) begin
      e.status = soi_pkg::ST_RANGE;
    end else begin
      e.status = soi_pkg::ST_OK;
      e.word   = pool_links[r.node*8 + r.slot];
      e.rlevel = pool_levels[r.node];
    end
    e.root = tree_level[4:0];
    e.used = pool_used[12:0];
    return e;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned exp);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h", field, got, exp);
    n_errors++;
  endtask

  // drive one request and hold it until accepted
  task automatic send_request(stim_row_t r);
    octree_res_t e;
    start_i       <= 1'b1;
    req_type_i    <= r.req;
    pos_x_i       <= r.x;
    pos_y_i       <= r.y;
    pos_z_i       <= r.z;
    voxel_color_i <= r.col;
    node_select_i <= r.node;
    slot_select_i <= r.slot;
    do @(posedge clk_i); while (busy_o);
    e = octree_predict(r);
    if (r.typed) e = '{r.status, r.leaf, r.root, r.used, r.word, r.rlevel};
    if (r.req == soi_pkg::REQ_INSERT) n_inserts++; else n_reads++;
    if (e.status == soi_pkg::ST_FULL) n_full++;
    if (e.status == soi_pkg::ST_RANGE) n_range++;
    pending_res.insert(pending_res.size(), e);
  endtask

  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g != 0) begin
      start_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [15:0] rand_coord();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 5) return 16'($signed($urandom_range(0, 15)) - 8);
    if (k < 8) return 16'($signed($urandom_range(0, 1023)) - 512);
    return 16'($urandom);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    octree_res_t e;
    if (rst_ni && done_o) begin
      if (pending_res.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = pending_res.pop_front();
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (leaf_node_o !== e.leaf) report_mismatch("leaf_node", leaf_node_o, e.leaf);
        if (root_size_o !== e.root) report_mismatch("root_size", root_size_o, e.root);
        if (used_count_o !== e.used) report_mismatch("used_count", used_count_o, e.used);
        if (read_word_o !== e.word) report_mismatch("read_word", read_word_o, e.word);
        if (read_level_o !== e.rlevel)
          report_mismatch("read_level", read_level_o, e.rlevel);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start_i && !busy_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", WD_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t r;
    int unsigned k;
    n_errors = 0; n_inserts = 0; n_reads = 0; n_full = 0; n_range = 0;
    idle_cycles = 0;
    rst_ni = 1'b0; start_i = 1'b0; req_type_i = soi_pkg::REQ_INSERT;
    pos_x_i = '0; pos_y_i = '0; pos_z_i = '0; voxel_color_i = '0;
    node_select_i = '0; slot_select_i = '0;
    for (int i = 0; i < NODES*8; i++) pool_links[i] = '0;
    for (int i = 0; i < NODES; i++) pool_levels[i] = '0;
    pool_used = 1;
    tree_level = soi_pkg::INITIAL_ROOT_SIZE_DEF;
    pool_levels[0] = tree_level[4:0];

    // directed table: typed rows hold results readable at a glance
    dir_tab = '{
      '{soi_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 1, soi_pkg::ST_OK, 0, 1, 1, 0, 1},
      '{soi_pkg::REQ_READ, 0, 0, 0, 0, 4095, 7, 1, soi_pkg::ST_RANGE, 0, 1, 1, 0, 0},
      '{soi_pkg::REQ_INSERT, 0, 0, 0, 0, 0, 0, 1, soi_pkg::ST_OK, 1, 1, 2, 0, 0},
      '{soi_pkg::REQ_READ, 0, 0, 0, 0, 1, 0, 1, soi_pkg::ST_OK, 0, 1, 2, 0, 0},
      '{soi_pkg::REQ_INSERT, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 1, soi_pkg::ST_OK,
        1, 1, 2, 0, 0},
      '{soi_pkg::REQ_READ, 0, 0, 0, 0, 1, 0, 1, soi_pkg::ST_OK, 0, 1, 2,
        32'hFFFF_FFFF, 0},
      '{soi_pkg::REQ_INSERT, -1, -1, -1, 32'hA5, 0, 0, 1, soi_pkg::ST_OK, 2, 1, 3, 0, 0},
      '{soi_pkg::REQ_INSERT, 32767, -32768, -1, 32'h1234_5678, 0, 0, 0,
        0, 0, 0, 0, 0, 0},
      '{soi_pkg::REQ_READ, 0, 0, 0, 0, 0, 7, 0, 0, 0, 0, 0, 0, 0},
      '{soi_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{soi_pkg::REQ_INSERT, -32768, 32767, 0, 32'h8000_0001, 0, 0, 0,
        0, 0, 0, 0, 0, 0},
      '{soi_pkg::REQ_INSERT, 2, 3, -4, 32'h0F0F_F0F0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{soi_pkg::REQ_READ, 0, 0, 0, 0, 3, 3, 0, 0, 0, 0, 0, 0, 0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_request(dir_tab[i]);
      idle_gap();
    end

    // random part: mostly inserts around a few clusters, plus reads
    for (int n = 0; n < N_RANDOM; n++) begin
      r = '{default: '0};
      k = $urandom_range(0, 9);
      r.req  = (k < 6) ? soi_pkg::REQ_INSERT : soi_pkg::REQ_READ;
      r.x    = rand_coord();
      r.y    = rand_coord();
      r.z    = rand_coord();
      r.col  = $urandom;
      r.slot = 3'($urandom);
      r.node = ($urandom_range(0, 4) == 0) ? 12'($urandom)
                                           : 12'($urandom_range(0, pool_used - 1));
      send_request(r);
      // once, hold off until the block has drained
      if (n == N_RANDOM / 2) begin
        start_i <= 1'b0;
        while (pending_res.size() != 0) @(posedge clk_i);
      end else begin
        idle_gap();
      end
    end
    start_i <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);

    $display("Covered %0d inserts and %0d reads; %0d pool-full, %0d out-of-range.",
             n_inserts, n_reads, n_full, n_range);
    $display("Final root level %0d with %0d of %0d nodes in use.",
             tree_level, pool_used, NODES);
    if (n_errors == 0 && pending_res.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, pending_res.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/soi_pkg.sv
rtl/core/soi_ram.sv
rtl/core/sparse_octree_insert.sv
tb/sparse_octree_insert_tb.sv
